// ===== hdl/sms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sms_pkg
// shared constants and codes for the superset match search block
// ----------------------------------------------------------------------------
package sms_pkg;

  // table geometry
  localparam int MAX_CELLS   = 1024;
  localparam int MARKER_BITS = 64;
  localparam int LANES       = 4;
  localparam int LANE_W      = $clog2(LANES);
  localparam int ROWS        = (MAX_CELLS + LANES - 1) / LANES;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W       = ROW_W + LANE_W;
  localparam int CNT_W       = $clog2(MAX_CELLS + 1);
  localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // fixed field widths
  localparam int MARKER_W    = 64;
  localparam int CELL_W      = 10;
  localparam int CELLS_CFG_W = 11;
  localparam int MARK_CFG_W  = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int STATUS_W    = 2;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKERS = 2'd1;

  // result codes
  localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNIQUE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_AMBIG  = 2'd2;

  // reset values
  localparam logic [CELLS_CFG_W-1:0] CELLS_RESET   = 11'd1024;
  localparam logic [MARK_CFG_W-1:0]  MARKERS_RESET = 7'd64;

endpackage
`default_nettype wire

// ===== hdl/sms_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sms_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/superset_match_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// superset_match_search
// marker superset search over a table of cell entries
// ----------------------------------------------------------------------------
// usage
//   requests: start with req_type, cell_index, cell_markers and query_mask;
//   a transfer happens at a clock edge with start high and busy low.
//   a write request stores cell_markers at cell_index in the same cycle and
//   gives no result; busy stays low, so writes may follow back to back.
//   a query request raises busy while the table is scanned four entries a
//   cycle through one shared four-lane compare unit. the table sits in four
//   lane rams with a registered read port. a query reads ceil(cells_in_use
//   / 4) rows, at least one, and then result_valid pulses for one cycle
//   with match_status and matched_cell.
//   a new request may be presented in the cycle of that pulse.
//   the receiver cannot stall; the result is only shown for that one cycle.
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; write only while no query is running.
//   reset (rst, synchronous) clears the sequencer and restores the register
//   defaults; the table contents are not cleared and need writing first.
// ----------------------------------------------------------------------------
module superset_match_search (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // request channel
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             req_type,
  input  wire logic [sms_pkg::CELL_W-1:0]       cell_index,
  input  wire logic [sms_pkg::MARKER_W-1:0]     cell_markers,
  input  wire logic [sms_pkg::MARKER_W-1:0]     query_mask,
  // result channel
  output logic                                  result_valid,
  output logic [sms_pkg::STATUS_W-1:0]          match_status,
  output logic [sms_pkg::CELL_W-1:0]            matched_cell,
  // configuration channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sms_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state;

  // configuration registers
  logic [sms_pkg::CELLS_CFG_W-1:0] cells_in_use;
  logic [sms_pkg::MARK_CFG_W-1:0]  markers_in_use;

  // query context, captured when the query is taken
  logic [sms_pkg::MARKER_W-1:0]    need;
  logic [sms_pkg::CNT_W-1:0]       ncells;
  logic [sms_pkg::ROW_W-1:0]       last_row;

  // read issue side
  logic [sms_pkg::ROW_W-1:0]       row;
  logic                            issue;

  // read return side, registered from the issue side in the cycle after it
  logic                            rd_vld;
  logic                            rd_last;
  logic [sms_pkg::ROW_W-1:0]       rd_row;

  // running tally: saturating hit count and first hit index
  logic [1:0]                      hits;
  logic [sms_pkg::IDX_W-1:0]       first;

  logic [sms_pkg::MARKER_W-1:0]    lane_data [sms_pkg::LANES];

  // next-value and decode signals
  logic                            req_go;
  logic                            wr_go;
  logic [sms_pkg::LANE_W-1:0]      wr_lane;
  logic [sms_pkg::ROW_W-1:0]       wr_row;
  logic [sms_pkg::MARKER_W-1:0]    need_next;
  logic [sms_pkg::CNT_W-1:0]       ncells_next;
  logic [sms_pkg::ROW_W-1:0]       last_row_next;
  logic [sms_pkg::LANES-1:0]       lane_hit;
  logic [2:0]                      lane_cnt;
  logic [sms_pkg::LANE_W-1:0]      first_lane;
  logic [2:0]                      hit_sum;
  logic [1:0]                      hits_next;
  logic [sms_pkg::IDX_W-1:0]       first_next;
  logic [sms_pkg::STATUS_W-1:0]    status_next;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign req_go    = start && !busy;

  // table writes go straight to the lane picked by the low index bits
  assign wr_go   = req_go && (req_type == sms_pkg::REQ_WRITE)
                   && (32'(cell_index) < sms_pkg::MAX_CELLS);
  assign wr_lane = cell_index[sms_pkg::LANE_W-1:0];
  assign wr_row  = sms_pkg::ROW_W'(cell_index >> sms_pkg::LANE_W);

  for (genvar l = 0; l < sms_pkg::LANES; l++) begin : g_lane
    sms_ram #(
      .WIDTH (sms_pkg::MARKER_W),
      .DEPTH (sms_pkg::ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (wr_go && (wr_lane == sms_pkg::LANE_W'(l))),
      .waddr (wr_row),
      .wdata (cell_markers),
      .raddr (row),
      .rdata (lane_data[l])
    );
  end

  // query setup: saturate the registers and mask off unused markers
  always_comb begin
    logic [sms_pkg::MARK_CFG_W-1:0] nmark;
    logic [sms_pkg::CNT_W-1:0]      ncells_m1;
    if (32'(markers_in_use) > sms_pkg::MARKER_BITS) begin
      nmark = sms_pkg::MARK_CFG_W'(sms_pkg::MARKER_BITS);
    end else begin
      nmark = markers_in_use;
    end
    for (int j = 0; j < sms_pkg::MARKER_W; j++) begin
      need_next[j] = query_mask[j] && (j < int'(nmark));
    end
    if (32'(cells_in_use) > sms_pkg::MAX_CELLS) begin
      ncells_next = sms_pkg::CNT_W'(sms_pkg::MAX_CELLS);
    end else begin
      ncells_next = sms_pkg::CNT_W'(cells_in_use);
    end
    // no cells still scans row zero, where every lane is out of use
    if (ncells_next == '0) begin
      ncells_m1 = '0;
    end else begin
      ncells_m1 = ncells_next - sms_pkg::CNT_W'(1);
    end
    last_row_next = sms_pkg::ROW_W'(ncells_m1 >> sms_pkg::LANE_W);
  end

  // shared compare unit: four entries of one row per cycle
  always_comb begin
    logic [sms_pkg::IDX_W-1:0] lane_idx;
    lane_cnt   = '0;
    first_lane = '0;
    for (int l = 0; l < sms_pkg::LANES; l++) begin
      lane_idx    = {rd_row, sms_pkg::LANE_W'(l)};
      lane_hit[l] = (sms_pkg::CMP_W'(lane_idx) < sms_pkg::CMP_W'(ncells))
                    && ((lane_data[l] & need) == need);
      lane_cnt    = lane_cnt + 3'(lane_hit[l]);
    end
    for (int l = sms_pkg::LANES - 1; l >= 0; l--) begin
      if (lane_hit[l]) begin
        first_lane = sms_pkg::LANE_W'(l);
      end
    end
    hit_sum = 3'(hits) + lane_cnt;
    if (hit_sum >= 3'd2) begin
      hits_next = 2'd2;
    end else begin
      hits_next = hit_sum[1:0];
    end
    if ((hits == 2'd0) && (lane_cnt != 3'd0)) begin
      first_next = {rd_row, first_lane};
    end else begin
      first_next = first;
    end
    unique case (hits_next)
      2'd0:    status_next = sms_pkg::STATUS_NONE;
      2'd1:    status_next = sms_pkg::STATUS_UNIQUE;
      default: status_next = sms_pkg::STATUS_AMBIG;
    endcase
  end

  // sequencer, configuration registers and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      issue          <= 1'b0;
      rd_vld         <= 1'b0;
      rd_last        <= 1'b0;
      result_valid   <= 1'b0;
      cells_in_use   <= sms_pkg::CELLS_RESET;
      markers_in_use <= sms_pkg::MARKERS_RESET;
    end else begin
      result_valid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sms_pkg::CFG_CELLS:   cells_in_use   <= cfg_data;
          sms_pkg::CFG_MARKERS: markers_in_use <= cfg_data[sms_pkg::MARK_CFG_W-1:0];
          default: ;
        endcase
      end

      // read return registers the issue side, so it follows in the next cycle
      rd_vld  <= issue;
      rd_last <= issue && (row == last_row);
      rd_row  <= row;

      unique case (state)
        ST_IDLE: begin
          if (req_go && (req_type == sms_pkg::REQ_QUERY)) begin
            state    <= ST_SCAN;
            need     <= need_next;
            ncells   <= ncells_next;
            last_row <= last_row_next;
            row      <= '0;
            issue    <= 1'b1;
            hits     <= 2'd0;
            first    <= '0;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            if (row == last_row) begin
              issue <= 1'b0;
            end else begin
              row <= row + sms_pkg::ROW_W'(1);
            end
          end
          if (rd_vld) begin
            hits  <= hits_next;
            first <= first_next;
            if (rd_last) begin
              state        <= ST_IDLE;
              result_valid <= 1'b1;
              match_status <= status_next;
              if (hits_next == 2'd1) begin
                matched_cell <= sms_pkg::CELL_W'(first_next);
              end else begin
                matched_cell <= '0;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a result marks the end of a scan
  a_result_ends_scan: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!busy && $past(busy)))
    else $error("result without a finished scan");

  // a result carries one of the three outcomes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((match_status == sms_pkg::STATUS_NONE)
                   || (match_status == sms_pkg::STATUS_UNIQUE)
                   || (match_status == sms_pkg::STATUS_AMBIG)))
    else $error("bad match status");

  // the index is zero unless the match is unique
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (match_status != sms_pkg::STATUS_UNIQUE)) |-> (matched_cell == '0))
    else $error("index set without a unique match");

  // read data only returns during a scan
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    (rd_vld || issue) |-> (state == ST_SCAN))
    else $error("table read outside a scan");
`endif

endmodule
`default_nettype wire
